// ===== hw/rtl/nsfc_pkg.sv =====
// Package for the NMEA sentence framer and checker: limits, character codes,
// status and sentence-kind codes, and the helper functions used by the datapath.
// Depends on nothing.
package nsfc_pkg;

   localparam int unsigned LINE_LIMIT       = 99;
   localparam int unsigned FIELD_LIMIT      = 24;
   localparam int unsigned FIELD_CHAR_LIMIT = 20;
   localparam int unsigned HEAD_CHARS       = 6;

   localparam int unsigned LINE_W     = $clog2(LINE_LIMIT + 1);
   localparam int unsigned FIELD_W    = $clog2(FIELD_LIMIT + 1);
   localparam int unsigned FCHAR_W    = $clog2(FIELD_CHAR_LIMIT + 1);
   localparam int unsigned HEAD_IDX_W = $clog2(HEAD_CHARS);

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CODE_W   = 3;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned RSUM_W   = 16;
   localparam int unsigned SLEN_W   = 7;
   localparam int unsigned DIGIT_W  = 6;
   localparam int unsigned KIND_NUM = 4;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CODE_W-1:0] code_type;
   typedef logic [HEAD_CHARS-1:0][BYTE_W-1:0] head_type;

   localparam byte_type CH_DOLLAR = 8'h24;
   localparam byte_type CH_CR     = 8'h0D;
   localparam byte_type CH_COMMA  = 8'h2C;
   localparam byte_type CH_STAR   = 8'h2A;

   localparam code_type ST_OK        = 3'd0;
   localparam code_type ST_MISMATCH  = 3'd1;
   localparam code_type ST_FIELDS    = 3'd2;
   localparam code_type ST_FIELD_LEN = 3'd3;
   localparam code_type ST_NO_STAR   = 3'd4;

   localparam code_type KIND_OTHER = 3'd0;

   // Index k holds the pattern reported as kind k + 1.
   localparam logic [KIND_NUM-1:0][3*BYTE_W-1:0] KIND_PAT = {"GSV", "GGA", "GSA", "RMC"};

   function automatic logic [DIGIT_W-1:0] digit_value(input byte_type b);
      logic [DIGIT_W-1:0] v;
      v = '0;
      if (b >= "0" && b <= "9") begin
         v = DIGIT_W'(b - "0");
      end else if (b >= "a" && b <= "z") begin
         v = DIGIT_W'(b - "a" + 8'd10);
      end else if (b >= "A" && b <= "Z") begin
         v = DIGIT_W'(b - "A" + 8'd10);
      end
      return v;
   endfunction

   function automatic code_type find_kind(input head_type head);
      code_type kind;
      kind = KIND_OTHER;
      for (int k = KIND_NUM - 1; k >= 0; k--) begin
         for (int off = 0; off + 3 <= HEAD_CHARS; off++) begin
            if ({head[off], head[off+1], head[off+2]} == KIND_PAT[k]) begin
               kind = CODE_W'(k + 1);
            end
         end
      end
      return kind;
   endfunction

endpackage

// ===== hw/rtl/nmea_sentence_framer_checker_unit.sv =====
// NMEA-0183 sentence framer and checksum checker, top level.
// Depends on nsfc_pkg for limits, codes and the digit and kind helpers.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_in_byte
//   rsp      out        rsp_valid/rsp_stall   rsp_status, rsp_sentence_kind,
//                                             rsp_field_count, rsp_computed_sum,
//                                             rsp_received_sum, rsp_sentence_length
//
// One byte is taken per cycle unless a carriage return waits on a stalled result; each
// byte is held in an input register while the sentence state is updated, and a carriage
// return inside a sentence loads the result register as it leaves the input register.
// Reset clears capture state and both valid flags.
// A stalled result blocks only a byte that would produce another result.
module nmea_sentence_framer_checker_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [nsfc_pkg::BYTE_W-1:0]   req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [nsfc_pkg::CODE_W-1:0]   rsp_status,
   output logic [nsfc_pkg::CODE_W-1:0]   rsp_sentence_kind,
   output logic [nsfc_pkg::COUNT_W-1:0]  rsp_field_count,
   output logic [nsfc_pkg::BYTE_W-1:0]   rsp_computed_sum,
   output logic [nsfc_pkg::RSUM_W-1:0]   rsp_received_sum,
   output logic [nsfc_pkg::SLEN_W-1:0]   rsp_sentence_length
);

   logic                            in_valid_ff;
   nsfc_pkg::byte_type              in_byte_ff;

   logic                            capturing_ff, capturing_in;
   logic [nsfc_pkg::LINE_W-1:0]     line_len_ff, line_len_in;
   nsfc_pkg::byte_type              xor_ff, xor_in;
   logic                            star_ff, star_in;
   logic [nsfc_pkg::RSUM_W-1:0]     hex_ff, hex_in;
   logic [nsfc_pkg::FIELD_W-1:0]    sep_cnt_ff, sep_cnt_in;
   logic [nsfc_pkg::FCHAR_W-1:0]    fchars_ff, fchars_in;
   nsfc_pkg::head_type              head_ff, head_in;
   nsfc_pkg::code_type              error_ff, error_in;

   logic                            rsp_valid_ff;
   nsfc_pkg::code_type              status_ff, status_in;
   nsfc_pkg::code_type              kind_ff;
   logic [nsfc_pkg::COUNT_W-1:0]    count_ff;
   nsfc_pkg::byte_type              csum_ff;
   logic [nsfc_pkg::RSUM_W-1:0]     rsum_ff;
   logic [nsfc_pkg::SLEN_W-1:0]     slen_ff;

   logic                            is_dollar, is_cr, is_sep, active, emit, out_free, fire;
   logic [nsfc_pkg::RSUM_W:0]       hex_sum;

   assign is_dollar = (in_byte_ff == nsfc_pkg::CH_DOLLAR);
   assign is_cr     = (in_byte_ff == nsfc_pkg::CH_CR);
   assign is_sep    = (in_byte_ff == nsfc_pkg::CH_COMMA) || (in_byte_ff == nsfc_pkg::CH_STAR);
   assign active    = is_dollar || capturing_ff;
   assign emit      = active && is_cr;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !fire;

   always_comb begin
      logic [nsfc_pkg::LINE_W-1:0] pos;

      line_len_in  = is_dollar ? '0 : line_len_ff;
      xor_in       = is_dollar ? '0 : xor_ff;
      star_in      = is_dollar ? 1'b0 : star_ff;
      hex_in       = is_dollar ? '0 : hex_ff;
      sep_cnt_in   = is_dollar ? '0 : sep_cnt_ff;
      fchars_in    = is_dollar ? '0 : fchars_ff;
      head_in      = is_dollar ? '0 : head_ff;
      error_in     = is_dollar ? nsfc_pkg::ST_OK : error_ff;
      capturing_in = active;
      pos          = line_len_in;
      hex_sum      = {1'b0, hex_in[nsfc_pkg::RSUM_W-5:0], 4'b0000}
                     + (nsfc_pkg::RSUM_W + 1)'(nsfc_pkg::digit_value(in_byte_ff));

      if (emit) begin
         capturing_in = 1'b0;
      end else if (active) begin
         if (pos < nsfc_pkg::LINE_W'(nsfc_pkg::HEAD_CHARS) && sep_cnt_in == '0 && !is_sep) begin
            head_in[pos[nsfc_pkg::HEAD_IDX_W-1:0]] =
               head_in[pos[nsfc_pkg::HEAD_IDX_W-1:0]] | in_byte_ff;
         end

         if (star_in) begin
            if (hex_in[nsfc_pkg::RSUM_W-1:nsfc_pkg::RSUM_W-4] != '0 || hex_sum[nsfc_pkg::RSUM_W])
            begin
               hex_in = '1;
            end else begin
               hex_in = hex_sum[nsfc_pkg::RSUM_W-1:0];
            end
         end else if (in_byte_ff == nsfc_pkg::CH_STAR) begin
            star_in = 1'b1;
         end else if (pos != '0) begin
            xor_in = xor_in ^ in_byte_ff;
         end

         if (error_in == nsfc_pkg::ST_OK) begin
            if (is_sep) begin
               sep_cnt_in = sep_cnt_in + 1'b1;
               fchars_in  = '0;
               if (sep_cnt_in >= nsfc_pkg::FIELD_W'(nsfc_pkg::FIELD_LIMIT)) begin
                  error_in = nsfc_pkg::ST_FIELDS;
               end
            end else begin
               fchars_in = fchars_in + 1'b1;
               if (fchars_in >= nsfc_pkg::FCHAR_W'(nsfc_pkg::FIELD_CHAR_LIMIT)) begin
                  error_in = nsfc_pkg::ST_FIELD_LEN;
               end
            end
         end

         line_len_in = pos + 1'b1;
         if (line_len_in >= nsfc_pkg::LINE_W'(nsfc_pkg::LINE_LIMIT)) begin
            capturing_in = 1'b0;
         end
      end

      if (error_ff != nsfc_pkg::ST_OK) begin
         status_in = error_ff;
      end else if (!star_ff) begin
         status_in = nsfc_pkg::ST_NO_STAR;
      end else if (nsfc_pkg::RSUM_W'(xor_ff) != hex_ff) begin
         status_in = nsfc_pkg::ST_MISMATCH;
      end else begin
         status_in = nsfc_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capturing_ff <= 1'b0;
         line_len_ff  <= '0;
         xor_ff       <= '0;
         star_ff      <= 1'b0;
         hex_ff       <= '0;
         sep_cnt_ff   <= '0;
         fchars_ff    <= '0;
         head_ff      <= '0;
         error_ff     <= nsfc_pkg::ST_OK;
      end else if (fire) begin
         capturing_ff <= capturing_in;
         line_len_ff  <= line_len_in;
         xor_ff       <= xor_in;
         star_ff      <= star_in;
         hex_ff       <= hex_in;
         sep_cnt_ff   <= sep_cnt_in;
         fchars_ff    <= fchars_in;
         head_ff      <= head_in;
         error_ff     <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire && emit) begin
         status_ff <= status_in;
         kind_ff   <= nsfc_pkg::find_kind(head_ff);
         count_ff  <= nsfc_pkg::COUNT_W'(sep_cnt_ff);
         csum_ff   <= xor_ff;
         rsum_ff   <= hex_ff;
         slen_ff   <= nsfc_pkg::SLEN_W'(line_len_ff);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_sentence_kind   = kind_ff;
   assign rsp_field_count     = count_ff;
   assign rsp_computed_sum    = csum_ff;
   assign rsp_received_sum    = rsum_ff;
   assign rsp_sentence_length = slen_ff;

   a_sep_bound: assert property (@(posedge clock) disable iff (reset)
      sep_cnt_ff <= nsfc_pkg::FIELD_W'(nsfc_pkg::FIELD_LIMIT))
      else $error("separator count above its limit");

   a_fchar_bound: assert property (@(posedge clock) disable iff (reset)
      fchars_ff <= nsfc_pkg::FCHAR_W'(nsfc_pkg::FIELD_CHAR_LIMIT))
      else $error("field character count above its limit");

   a_capture_len: assert property (@(posedge clock) disable iff (reset)
      capturing_ff |-> line_len_ff < nsfc_pkg::LINE_W'(nsfc_pkg::LINE_LIMIT))
      else $error("capture still open at the line limit");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      fire && emit |=> rsp_valid)
      else $error("carriage return did not load a result");

   a_error_freeze: assert property (@(posedge clock) disable iff (reset)
      error_ff != nsfc_pkg::ST_OK && !(fire && is_dollar) |=> $stable(sep_cnt_ff))
      else $error("separator count moved after a field error");

endmodule
